// ===== rtl/spq_pkg.sv =====
// Shared types and result codes of the sorted priority queue.
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] priority_lvl;
    } entry_t;

endpackage

// ===== rtl/spq_if.sv =====
// Handshake channels of the sorted priority queue: requests, results, configuration.
interface spq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic signed [spq_pkg::DATA_W-1:0]   item_value;
    logic signed [spq_pkg::DATA_W-1:0]   item_priority;

    modport source (output valid, command, item_value, item_priority, input ready);
    modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [spq_pkg::STAT_W-1:0]   status;
    logic signed [spq_pkg::DATA_W-1:0]   out_value;
    logic signed [spq_pkg::DATA_W-1:0]   out_priority;
    logic        [spq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_value, out_priority, occupancy, input ready);
    modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

interface spq_cfg_if;
    logic                                valid;
    logic                                ready;
    logic        [spq_pkg::CAP_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: entry memory, shift sequencer and result register.
//
// Usage. Requests arrive on req: command 0 inserts (item_value, item_priority),
// command 1 removes the head entry. Each request yields one item on rsp with a
// status, the removed pair (zero unless removed) and the occupancy afterwards.
// Entries sit in a single-port-write, single-port-read memory in descending
// priority order; equal priorities leave first in, first out.
// Timing. One request is worked at a time and req.ready is low meanwhile. An
// insert walks the memory from the tail, one compare-and-move per cycle on the
// shared read/write port pair. A remove reads the head then moves each
// remaining entry up one place. Rejected requests and inserts into an empty
// queue go straight to the result. Each move uses the entry that the memory
// read registered in the step before.
// cfg writes the capacity (reset 16, clipped to DEPTH); write it only while idle.
// Reset empties the queue and returns the capacity to 16; memory contents need
// no clearing, as only entries below the count are ever read.
// Stall. A finished result waits in the sequencer until the rsp register is
// free, so a stalled receiver holds the block busy; rsp holds its item stably.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    spq_cfg_if.sink      cfg,
    spq_req_if.sink      req,
    spq_rsp_if.source    rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS       = 3'd1;
    localparam logic [2:0] S_INS_LAST  = 3'd2;
    localparam logic [2:0] S_REM_HEAD  = 3'd3;
    localparam logic [2:0] S_REM_SHIFT = 3'd4;
    localparam logic [2:0] S_FIN       = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [spq_pkg::CAP_W-1:0]       cap_reg;
    logic [AW-1:0]                   idx_reg, idx_next;
    spq_pkg::entry_t                 new_reg, new_next;
    logic [spq_pkg::STAT_W-1:0]      res_status_reg, res_status_next;
    spq_pkg::entry_t                 res_entry_reg, res_entry_next;

    logic                            out_valid_reg, out_valid_next;
    logic [spq_pkg::STAT_W-1:0]      out_status_reg, out_status_next;
    spq_pkg::entry_t                 out_entry_reg, out_entry_next;
    logic [spq_pkg::OCC_W-1:0]       out_occ_reg, out_occ_next;

    // entry memory
    spq_pkg::entry_t                 mem [DEPTH];
    spq_pkg::entry_t                 rd_data_reg;
    logic                            mem_we, mem_re;
    logic [AW-1:0]                   mem_waddr, mem_raddr;
    spq_pkg::entry_t                 mem_wdata;

    logic                            req_fire, slot_free, full;
    logic [CW-1:0]                   count_done;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign slot_free = !out_valid_reg || rsp.ready;

    // full when at the configured limit or at the built depth
    assign full = (WW'(count_reg) >= WW'(cap_reg)) || (count_reg >= DEPTH_C);

    // count after the finished request
    always_comb
    begin
        case (res_status_reg)
            spq_pkg::ST_INSERTED: count_done = count_reg + CW'(1);
            spq_pkg::ST_REMOVED:  count_done = count_reg - CW'(1);
            default:              count_done = count_reg;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_occ_next    = out_occ_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = new_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    new_next       = '{value: req.item_value, priority_lvl: req.item_priority};
                    res_entry_next = '0;
                    if (req.command == spq_pkg::CMD_INSERT)
                    begin
                        if (full)
                        begin
                            res_status_next = spq_pkg::ST_FULL;
                            state_next      = S_FIN;
                        end
                        else if (count_reg == '0)
                        begin
                            // empty queue: drop the pair straight into the head
                            mem_we          = 1'b1;
                            mem_waddr       = '0;
                            mem_wdata       = '{value: req.item_value,
                                                priority_lvl: req.item_priority};
                            res_status_next = spq_pkg::ST_INSERTED;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            idx_next   = count_reg[AW-1:0];
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(count_reg - CW'(1));
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = spq_pkg::ST_EMPTY;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_REM_HEAD;
                        end
                    end
                end
            end

            S_INS:
            begin
                // rd_data_reg holds entry idx-1; move it back while the new one outranks it
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (new_reg.priority_lvl > rd_data_reg.priority_lvl)
                begin
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg - AW'(2);
                    end
                end
                else
                begin
                    mem_wdata       = new_reg;
                    res_status_next = spq_pkg::ST_INSERTED;
                    state_next      = S_FIN;
                end
            end

            S_INS_LAST:
            begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = new_reg;
                res_status_next = spq_pkg::ST_INSERTED;
                state_next      = S_FIN;
            end

            S_REM_HEAD:
            begin
                res_entry_next  = rd_data_reg;
                res_status_next = spq_pkg::ST_REMOVED;
                if (count_reg == CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = AW'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(1);
                    state_next = S_REM_SHIFT;
                end
            end

            S_REM_SHIFT:
            begin
                // close the gap: entry idx moves up to idx-1
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = rd_data_reg;
                if (CW'(idx_reg) == count_reg - CW'(1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                end
            end

            S_FIN:
            begin
                // hold until the result register is free
                if (slot_free)
                begin
                    count_next      = count_done;
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                    out_occ_next    = spq_pkg::OCC_W'(count_done);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= spq_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_occ_reg    <= out_occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.out_value    = out_entry_reg.value;
    assign rsp.out_priority = out_entry_reg.priority_lvl;
    assign rsp.occupancy    = out_occ_reg;

    // never more entries than the memory holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    // an accepted request keeps the block busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("ready again straight after accepting a request");

    // only a remove carries a pair out
    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != spq_pkg::ST_REMOVED)
        |-> (rsp.out_value == '0) && (rsp.out_priority == '0))
        else $error("non-zero pair on a result that removed nothing");

    // an empty rejection reports an empty queue
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == spq_pkg::ST_EMPTY) |-> (rsp.occupancy == '0))
        else $error("empty rejection with entries held");

    // a result is loaded only as the sequencer returns to idle
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && slot_free |=> rsp.valid && (state_reg == S_IDLE))
        else $error("result not presented on completion");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench of the sorted priority queue: stimulus, predictor and result check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    // Longest request plus the result register; settle well past it.
    localparam int SETTLE_CYC  = DEPTH + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYC    = 500;

    typedef struct {
        logic                              cmd;
        logic signed [spq_pkg::DATA_W-1:0] val;
        logic signed [spq_pkg::DATA_W-1:0] pri;
    } request_t;

    typedef struct {
        logic        [spq_pkg::STAT_W-1:0] status;
        logic signed [spq_pkg::DATA_W-1:0] value;
        logic signed [spq_pkg::DATA_W-1:0] prio;
        logic        [spq_pkg::OCC_W-1:0]  occ;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    spq_cfg_if cfg ();
    spq_req_if req ();
    spq_rsp_if rsp ();

    sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    always #1 clk = ~clk;

    // Shadow copy of the queue contents and its capacity register.
    logic signed [spq_pkg::DATA_W-1:0] shadow_val [DEPTH];
    logic signed [spq_pkg::DATA_W-1:0] shadow_pri [DEPTH];
    int                                shadow_count = 0;
    int                                shadow_cap   = spq_pkg::CAP_RESET;

    request_t pending_requests [$];
    result_t  awaited_results  [$];

    int  items_queued = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    // Set for the last part of the run: no idling on either side.
    bit  calm         = 1'b0;
    // Long receiver hold-off, timed by its own process.
    bit  hold_on      = 1'b0;

    task automatic note_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    // Work out the result of one request and advance the shadow queue.
    function automatic result_t serve_request(input request_t r);
        result_t res;
        int      lim;
        int      pos;
        res.status = spq_pkg::ST_INSERTED;
        res.value  = '0;
        res.prio   = '0;
        lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        if (r.cmd == spq_pkg::CMD_INSERT)
        begin
            if (shadow_count >= lim)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // Entries run in descending priority, so the strictly lower ones
                // form a tail; the new pair goes in front of that tail.
                pos = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                begin
                    if (r.pri > shadow_pri[i])
                        pos = i;
                end
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_val[i] = shadow_val[i-1];
                    shadow_pri[i] = shadow_pri[i-1];
                end
                shadow_val[pos] = r.val;
                shadow_pri[pos] = r.pri;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            res.status = spq_pkg::ST_EMPTY;
        end
        else
        begin
            res.status = spq_pkg::ST_REMOVED;
            res.value  = shadow_val[0];
            res.prio   = shadow_pri[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_val[i-1] = shadow_val[i];
                shadow_pri[i-1] = shadow_pri[i];
            end
            shadow_count--;
        end
        res.occ = shadow_count[spq_pkg::OCC_W-1:0];
        return res;
    endfunction

    // Request driver: offer queued items, predict on every accepted one,
    // and drop in random idle bursts between items.
    int gap_left = 0;

    always @(posedge clk)
    begin : drive_requests
        request_t nxt;
        bit       offer;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            offer         = req.valid;
            nxt.cmd       = req.command;
            nxt.val       = req.item_value;
            nxt.pri       = req.item_priority;
            if (req.valid && req.ready)
            begin
                awaited_results.push_back(serve_request(nxt));
                offer = 1'b0;
                if (!calm && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_requests.size() > 0)
                begin
                    nxt   = pending_requests.pop_front();
                    offer = 1'b1;
                end
            end
            // One assignment per signal per edge: valid stays high across items.
            req.valid         <= offer;
            req.command       <= nxt.cmd;
            req.item_value    <= nxt.val;
            req.item_priority <= nxt.pri;
        end
    end

    // Hold the receiver off for a long stretch twice, so the block fills
    // and stalls its input while the sender keeps offering.
    initial
    begin : hold_receiver
        wait (results_seen >= 250);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_on <= 1'b0;
        wait (results_seen >= 900);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Result monitor: check each accepted item against the oldest prediction,
    // and stall the receiver in bursts, twice for a long stretch.
    int stall_left = 0;

    always @(posedge clk)
    begin : check_results
        result_t want;
        bit      take;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    note_mismatch("result item with nothing awaited");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status)
                        note_mismatch($sformatf("status %0d, want %0d",
                                                rsp.status, want.status));
                    if (rsp.out_value !== want.value)
                        note_mismatch($sformatf("out_value %0d, want %0d",
                                                rsp.out_value, want.value));
                    if (rsp.out_priority !== want.prio)
                        note_mismatch($sformatf("out_priority %0d, want %0d",
                                                rsp.out_priority, want.prio));
                    if (rsp.occupancy !== want.occ)
                        note_mismatch($sformatf("occupancy %0d, want %0d",
                                                rsp.occupancy, want.occ));
                end
                results_seen++;
            end
            if (hold_on)
            begin
                take = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                take = 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                take = 1'b0;
            end
            else
            begin
                take = 1'b1;
            end
            rsp.ready <= take;
        end
    end

    // Watchdog.
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_request(input logic cmd, input logic [spq_pkg::DATA_W-1:0] val,
                               input logic [spq_pkg::DATA_W-1:0] pri);
        request_t r;
        r.cmd = cmd;
        r.val = val;
        r.pri = pri;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    // Random priority: often a narrow band or an extreme, so that ties are frequent.
    function automatic logic [spq_pkg::DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4, 5: return $urandom_range(0, 3) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random(input int n, input int insert_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1, 100) <= insert_pct)
                add_request(spq_pkg::CMD_INSERT, $urandom, pick_priority());
            else
                add_request(spq_pkg::CMD_REMOVE, $urandom, $urandom);
        end
    endtask

    // Wait until every queued item has come back, then let the block go quiet.
    task automatic settle();
        while (results_seen != items_queued)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [spq_pkg::CAP_W-1:0] v);
        settle();
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        shadow_cap = v;
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg.valid         = 1'b0;
        cfg.data          = '0;
        req.valid         = 1'b0;
        req.command       = spq_pkg::CMD_INSERT;
        req.item_value    = '0;
        req.item_priority = '0;
        rsp.ready         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset capacity: remove from empty with a busy
        // payload, extreme values and priorities, ties served in arrival order.
        add_request(spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        add_request(spq_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        add_request(spq_pkg::CMD_INSERT, 32'd0, 32'd0);
        add_request(spq_pkg::CMD_INSERT, 32'd1, 32'd0);
        add_request(spq_pkg::CMD_INSERT, 32'd2, 32'd0);
        add_request(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(spq_pkg::CMD_INSERT, 32'd3, 32'h7FFF_FFFF);
        for (int i = 0; i < 8; i++)
            add_request(spq_pkg::CMD_REMOVE, $urandom, $urandom);

        // Capacity of one: second insert is rejected as full.
        write_capacity(5'd1);
        add_request(spq_pkg::CMD_INSERT, 32'd10, 32'd5);
        add_request(spq_pkg::CMD_INSERT, 32'd11, 32'd6);
        add_request(spq_pkg::CMD_REMOVE, 32'd0, 32'd0);
        add_request(spq_pkg::CMD_REMOVE, 32'd0, 32'd0);

        // Capacity zero: every insert is rejected.
        write_capacity(5'd0);
        add_request(spq_pkg::CMD_INSERT, 32'd12, 32'd7);
        add_request(spq_pkg::CMD_REMOVE, 32'd0, 32'd0);

        // Capacity above the built depth clips to it.
        write_capacity(5'd31);
        add_random(300, 60);

        write_capacity(5'd16);
        add_random(300, 70);
        for (int i = 0; i < DEPTH; i++)
            add_request(spq_pkg::CMD_INSERT, $urandom, pick_priority());

        // Lower the capacity under the occupancy: entries are kept, inserts
        // are turned away until removes bring the count down.
        write_capacity(5'd3);
        add_random(200, 45);

        write_capacity(5'd0);
        add_random(30, 50);

        write_capacity(5'd7);
        add_random(250, 60);

        write_capacity(5'd1);
        add_random(100, 55);

        // Last part: full rate on both sides.
        write_capacity(5'd16);
        calm = 1'b1;
        add_random(400, 65);

        settle();
        if (awaited_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
